>>> src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlfd_pkg.sv
// Shared types, constants and the frame tag table for the deframer.
// No dependencies.
package tlfd_pkg;

    localparam int unsigned LEN_W      = 21;
    localparam int unsigned VER_W      = 7;
    localparam int unsigned HDR_BYTES  = 11;
    localparam int unsigned TAG_BYTES  = 6;

    localparam logic [LEN_W-1:0] LEN_CAP     = 21'h10_0000;
    localparam logic [LEN_W-1:0] LEN_RESET   = 21'h10_0000;
    localparam logic [VER_W-1:0] VER_RESET   = 7'h01;

    // result status codes
    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_BODY   = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_MAX_VER = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] max_body_length;
        logic [VER_W-1:0] max_version;
    } cfg_t;

    // expected tag characters, one per tag position
    function automatic logic [7:0] tag_byte(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h54;
            3'd1:    c = 8'h43;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h53;
            3'd4:    c = 8'h41;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> src/tagged_length_frame_deframer_core.sv
// Top level of the tagged length-prefixed frame deframer.
// Depends on tlfd_pkg, tlfd_cfg_regs and assert_macros.svh.
//
// Usage:
//   s_* channel takes one received stream byte per word (s_data_byte).
//   m_* channel returns one result word per input word: status (header,
//   body, error), the body byte, a last-of-frame flag and the frame length.
//   Each frame is an 11-byte header (6-byte tag, 32-bit big-endian length,
//   signed version byte) followed by the body.
//   Result valid follows in the cycle after input accept. Throughput: one
//   word per cycle while the receiver is not stalling; the header check
//   is a single compare stage between input handshake and result register.
//   The result register doubles as the skid stage: s_ready is high whenever
//   the result register is empty or is being drained, so a stalled receiver
//   holds the result and backpressures the input after one word.
//   Reset (aresetn low, synchronous) returns to header phase, empties the
//   result register and restores register defaults. A header error makes
//   every later word report error until reset.
//   Limits are written on the APB port while idle; they apply at the next
//   header check.
`include "assert_macros.svh"

module tagged_length_frame_deframer_core
    import tlfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // input byte stream
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    // result stream
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [7:0]       m_payload_byte,
    output logic             m_last_of_frame,
    output logic [LEN_W-1:0] m_frame_length,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    localparam logic [3:0] LAST_HDR  = 4'(HDR_BYTES - 1);
    localparam logic [3:0] TAG_END   = 4'(TAG_BYTES);
    localparam logic [3:0] LEN_END   = 4'(TAG_BYTES + 4);

    cfg_t cfg;

    tlfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser state
    logic [1:0]       phase_reg, phase_next;
    logic [3:0]       hcount_reg, hcount_next;
    logic             tag_ok_reg, tag_ok_next;
    logic [31:0]      acc_reg, acc_next;
    logic [LEN_W-1:0] remain_reg, remain_next;

    // result register
    logic             m_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       payload_reg, payload_next;
    logic             last_reg, last_next;
    logic [LEN_W-1:0] flen_reg, flen_next;

    logic             s_fire;
    logic [LEN_W-1:0] lim;
    logic             ver_bad;
    logic             hdr_bad;
    logic [LEN_W-1:0] left;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // header check terms
    assign lim     = (cfg.max_body_length > LEN_CAP) ? LEN_CAP : cfg.max_body_length;
    assign ver_bad = !s_data_byte[7] && (s_data_byte[6:0] > cfg.max_version);
    assign hdr_bad = !tag_ok_reg || ver_bad || (acc_reg == 32'h0)
                     || (acc_reg > {{(32-LEN_W){1'b0}}, lim});
    assign left    = (remain_reg == '0) ? '0 : remain_reg - 1'b1;

    // next state and result for one byte
    always_comb begin
        phase_next   = phase_reg;
        hcount_next  = hcount_reg;
        tag_ok_next  = tag_ok_reg;
        acc_next     = acc_reg;
        remain_next  = remain_reg;
        status_next  = ST_ERROR;
        payload_next = 8'h00;
        last_next    = 1'b0;
        flen_next    = '0;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hcount_reg < TAG_END) begin
                    if (s_data_byte != tag_byte(hcount_reg[2:0])) begin
                        tag_ok_next = 1'b0;
                    end
                end else if (hcount_reg < LEN_END) begin
                    acc_next = {acc_reg[23:0], s_data_byte};
                end
                if (hcount_reg != LAST_HDR) begin
                    hcount_next = hcount_reg + 4'd1;
                    status_next = ST_HEADER;
                end else begin
                    hcount_next = 4'd0;
                    tag_ok_next = 1'b1;
                    if (hdr_bad) begin
                        phase_next  = PH_ERROR;
                        status_next = ST_ERROR;
                    end else begin
                        phase_next  = PH_BODY;
                        remain_next = acc_reg[LEN_W-1:0];
                        status_next = ST_HEADER;
                        flen_next   = acc_reg[LEN_W-1:0];
                    end
                end
            end
            PH_BODY: begin
                remain_next  = left;
                status_next  = ST_BODY;
                payload_next = s_data_byte;
                last_next    = (left == '0);
                flen_next    = acc_reg[LEN_W-1:0];
                if (left == '0) begin
                    phase_next  = PH_HEADER;
                    hcount_next = 4'd0;
                    tag_ok_next = 1'b1;
                end
            end
            default: begin
                phase_next  = PH_ERROR;
                status_next = ST_ERROR;
            end
        endcase
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= 4'd0;
            tag_ok_reg <= 1'b1;
            acc_reg    <= 32'h0;
            remain_reg <= '0;
        end else if (s_fire) begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            tag_ok_reg <= tag_ok_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
            last_reg    <= last_next;
            flen_reg    <= flen_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_payload_byte  = payload_reg;
    assign m_last_of_frame = last_reg;
    assign m_frame_length  = flen_reg;

    // error phase is sticky until reset
    `ASSERT_NEXT(a_error_sticky, aclk, aresetn, phase_reg == PH_ERROR,
                 phase_reg == PH_ERROR, "error phase left without reset")
    // header position never runs past the version byte
    `ASSERT_ALWAYS(a_hcount_range, aclk, aresetn, hcount_reg <= LAST_HDR,
                   "header count out of range")
    // in body phase at least one body byte is still owed
    `ASSERT_ALWAYS(a_body_remain, aclk, aresetn,
                   (phase_reg != PH_BODY) || (remain_reg != '0),
                   "body phase with nothing remaining")
    // last flag only on body results
    `ASSERT_ALWAYS(a_last_body, aclk, aresetn,
                   !(m_valid_reg && last_reg) || (status_reg == ST_BODY),
                   "last flag on non-body result")

endmodule

>>> src/tlfd_cfg_regs.sv
// APB-style configuration registers: body length limit and version limit.
// Depends on tlfd_pkg.
module tlfd_cfg_regs
    import tlfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [LEN_W-1:0] max_len_reg;
    logic [VER_W-1:0] max_ver_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, decoded on the word address bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_RESET;
            max_ver_reg <= VER_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MAX_LEN: max_len_reg <= pwdata[LEN_W-1:0];
                REG_MAX_VER: max_ver_reg <= pwdata[VER_W-1:0];
                default:     max_len_reg <= max_len_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            REG_MAX_LEN: prdata = {{(32-LEN_W){1'b0}}, max_len_reg};
            REG_MAX_VER: prdata = {{(32-VER_W){1'b0}}, max_ver_reg};
            default:     prdata = 32'h0;
        endcase
    end

    assign cfg.max_body_length = max_len_reg;
    assign cfg.max_version     = max_ver_reg;

endmodule
